// ===== rtl/core/isolated_point_removal_3x3_assert.svh =====
// ----------------------------------------------------------------------------
// Isolated point removal assertion macros
// Concurrent check wrappers shared by the RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ISOLATED_POINT_REMOVAL_3X3_ASSERT_SVH
`define ISOLATED_POINT_REMOVAL_3X3_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge outside reset
`define IPR_ASSERT(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle
`define IPR_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error(msg);

`else

`define IPR_ASSERT(label, clk, rst, cond, msg)
`define IPR_ASSERT_NEXT(label, clk, rst, trig, cons, msg)

`endif

`endif

// ===== rtl/core/ipr_pkg.sv =====
// ----------------------------------------------------------------------------
// Isolated point removal package
// Geometry constants, register codes and the request queue entry type.
// ----------------------------------------------------------------------------
package ipr_pkg;

   // Map geometry limits
   localparam int MAX_LINE = 128;
   localparam int MAX_ROWS = 1024;
   localparam int COL_W    = $clog2(MAX_LINE);
   localparam int ROW_W    = $clog2(MAX_ROWS);

   // Register widths
   localparam int LEN_W      = 8;
   localparam int CNT_W      = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_COUNT  = 2'd2;

   // Reset values
   localparam logic [LEN_W-1:0] LENGTH_RESET = 8'd128;
   localparam logic [CNT_W-1:0] COUNT_RESET  = 11'd800;

   // Line store: two bits per column (row r-2, row r-1)
   localparam int LINE_W = 2;

   // Result slots of one request
   localparam int SLOTS = 3;
   localparam int SLOT_INNER  = 0;   // point up and left, filtered
   localparam int SLOT_BORDER = 1;   // point above, right border column
   localparam int SLOT_BOTTOM = 2;   // point itself, bottom border row

   // Queue between front and back
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic [SLOTS-1:0] slot_valid;
      logic [SLOTS-1:0] slot_flag;
   } ipr_entry_type;

endpackage

// ===== rtl/core/ipr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered data; a write and a read of
// the same address in one cycle return the new data.
// ----------------------------------------------------------------------------
module ipr_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register read data, forward a same-address write
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ipr_front.sv =====
// ----------------------------------------------------------------------------
// Isolated point removal front end
// Holds configuration and raster counters, keeps the previous two rows in a
// line store, builds the 3x3 window and classifies each request into up to
// three results that go to the queue as one entry.
// ----------------------------------------------------------------------------
`include "isolated_point_removal_3x3_assert.svh"

module ipr_front import ipr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_flag_in,
   output logic                  req_full,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [QCNT_W-1:0]     q_count,
   output logic                  q_push,
   output ipr_entry_type         q_entry
);

   // Configuration
   logic             enable_ff;
   logic [LEN_W-1:0] length_ff;
   logic [CNT_W-1:0] count_ff;
   logic [LEN_W-1:0] len_eff;
   logic [CNT_W-1:0] cnt_eff;

   // Raster position of the next request
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             accept;
   logic             col_end;
   logic             row_end;
   logic             geom_write;

   // First stage, line store read in flight
   logic             s1_valid_ff;
   logic             s1_flag_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [SLOTS-1:0] s1_slot_ff, s1_slot_in;
   logic             s1_inner_ff, s1_inner_in;

   // Window columns: bit 2 row r-2, bit 1 row r-1, bit 0 row r
   logic [2:0]        win_p1_ff;
   logic [2:0]        win_p2_ff;
   logic [2:0]        win_new;
   logic [LINE_W-1:0] line_rd;
   logic [LINE_W-1:0] line_wr;
   logic              center;
   logic              neighbor_any;
   logic              inner_flag;

   // Derive the clamped geometry
   always_comb begin
      if (length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (length_ff > MAX_LINE) begin
         len_eff = LEN_W'(MAX_LINE);
      end else begin
         len_eff = length_ff;
      end
      if (count_ff == '0) begin
         cnt_eff = CNT_W'(1);
      end else if (count_ff > MAX_ROWS) begin
         cnt_eff = CNT_W'(MAX_ROWS);
      end else begin
         cnt_eff = count_ff;
      end
   end

   // Stall when the queue could not absorb the requests in flight
   assign req_full = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_ff)) >= QDEPTH;
   assign accept   = req_push && !req_full;

   // Classify the position of the arriving request
   assign col_end = ((LEN_W)'(col_ff) + LEN_W'(1)) == len_eff;
   assign row_end = ((CNT_W)'(row_ff) + CNT_W'(1)) == cnt_eff;

   always_comb begin
      s1_slot_in[SLOT_INNER]  = (row_ff != '0) && (col_ff != '0);
      s1_slot_in[SLOT_BORDER] = (row_ff != '0) && col_end;
      s1_slot_in[SLOT_BOTTOM] = row_end;
      s1_inner_in = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   end

   // Advance the raster counters
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      if (geom_write) begin
         row_in = '0;
         col_in = '0;
      end
   end

   assign geom_write = csr_valid &&
                       ((csr_index == CSR_LINE_LENGTH) || (csr_index == CSR_LINE_COUNT));

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         length_ff <= LENGTH_RESET;
         count_ff  <= COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:      enable_ff <= csr_data[0];
            CSR_LINE_LENGTH: length_ff <= csr_data[LEN_W-1:0];
            CSR_LINE_COUNT:  count_ff  <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Hold counters and first stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= accept;
      end
   end

   // Capture request payload for the first stage
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flag_ff  <= req_flag_in;
         s1_row_ff   <= row_ff;
         s1_col_ff   <= col_ff;
         s1_slot_ff  <= s1_slot_in;
         s1_inner_ff <= s1_inner_in;
      end
   end

   // Line store of the two previous rows, shifted down by one row per write
   assign line_wr = {line_rd[0], s1_flag_ff};

   ipr_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_LINE)
   ) u_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   // Decide the point up and left of the request
   assign win_new      = {line_rd[1], line_rd[0], s1_flag_ff};
   assign center       = win_p1_ff[1];
   assign neighbor_any = (|win_p2_ff) | win_p1_ff[2] | win_p1_ff[0] | (|win_new);
   assign inner_flag   = (center && enable_ff && s1_inner_ff) ? neighbor_any : center;

   // Shift the window by one column
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_p2_ff <= win_p1_ff;
         win_p1_ff <= win_new;
      end
   end

   // Drop requests that cause no result, push the rest
   assign q_push = s1_valid_ff && (|s1_slot_ff);

   always_comb begin
      q_entry.row                     = s1_row_ff;
      q_entry.column                  = s1_col_ff;
      q_entry.slot_valid              = s1_slot_ff;
      q_entry.slot_flag[SLOT_INNER]   = inner_flag;
      q_entry.slot_flag[SLOT_BORDER]  = win_new[1];
      q_entry.slot_flag[SLOT_BOTTOM]  = s1_flag_ff;
   end

   `IPR_ASSERT(a_col_in_line, clock, reset, (LEN_W)'(col_ff) < len_eff,
               "column counter beyond line length")
   `IPR_ASSERT(a_row_in_frame, clock, reset, (CNT_W)'(row_ff) < cnt_eff,
               "row counter beyond line count")

endmodule

// ===== rtl/core/ipr_queue.sv =====
// ----------------------------------------------------------------------------
// Isolated point removal queue
// Short FIFO of classified requests between the front end and the back end.
// ----------------------------------------------------------------------------
`include "isolated_point_removal_3x3_assert.svh"

module ipr_queue import ipr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ipr_entry_type     push_entry,
   input  logic              pop,
   output ipr_entry_type     head_entry,
   output logic              empty,
   output logic [QCNT_W-1:0] count
);

   ipr_entry_type     entries_ff [QDEPTH];
   logic [QPTR_W-1:0] head_ff;
   logic [QPTR_W-1:0] tail_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_pop;

   assign do_pop = pop && (count_ff != '0);

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= push_entry;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            head_ff <= head_ff + QPTR_W'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   assign head_entry = entries_ff[head_ff];
   assign empty      = (count_ff == '0);
   assign count      = count_ff;

   `IPR_ASSERT(a_no_overflow, clock, reset, !(push && (count_ff == QCNT_W'(QDEPTH))),
               "push into a full queue")
   `IPR_ASSERT_NEXT(a_push_shows, clock, reset, push && !do_pop, count_ff != '0,
                    "pushed entry not counted")

endmodule

// ===== rtl/core/ipr_back.sv =====
// ----------------------------------------------------------------------------
// Isolated point removal back end
// Walks the result slots of the queue head, presents one result at a time
// and releases the entry after its last result is taken.
// ----------------------------------------------------------------------------
`include "isolated_point_removal_3x3_assert.svh"

module ipr_back import ipr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ipr_entry_type    head_entry,
   input  logic             q_empty,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [ROW_W-1:0] rsp_row,
   output logic [COL_W-1:0] rsp_column,
   output logic             rsp_flag_out,
   output logic             rsp_last
);

   logic [SLOTS-1:0] done_ff, done_in;
   logic [SLOTS-1:0] pending;
   logic [SLOTS-1:0] sel;
   logic             take;

   // Pick the oldest pending slot
   assign pending = head_entry.slot_valid & ~done_ff;
   assign sel     = pending & (~pending + SLOTS'(1));
   assign rsp_last  = ((pending & ~sel) == '0);
   assign rsp_empty = q_empty;
   assign take      = rsp_pop && !q_empty;
   assign q_pop     = take && rsp_last;

   // Present the selected result
   always_comb begin
      rsp_row      = head_entry.row;
      rsp_column   = head_entry.column;
      rsp_flag_out = head_entry.slot_flag[SLOT_BOTTOM];
      case (sel)
         SLOTS'(1) << SLOT_INNER: begin
            rsp_row      = head_entry.row - ROW_W'(1);
            rsp_column   = head_entry.column - COL_W'(1);
            rsp_flag_out = head_entry.slot_flag[SLOT_INNER];
         end
         SLOTS'(1) << SLOT_BORDER: begin
            rsp_row      = head_entry.row - ROW_W'(1);
            rsp_flag_out = head_entry.slot_flag[SLOT_BORDER];
         end
         default: ;
      endcase
   end

   // Mark taken slots, clear when the entry leaves
   always_comb begin
      done_in = done_ff;
      if (take) begin
         done_in = rsp_last ? '0 : (done_ff | sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else begin
         done_ff <= done_in;
      end
   end

   `IPR_ASSERT(a_head_pending, clock, reset, q_empty || $onehot(sel),
               "queue head has no pending result")

endmodule

// ===== rtl/core/isolated_point_removal_3x3.sv =====
// ----------------------------------------------------------------------------
// Isolated point removal, 3x3
// Streaming removal of isolated set points from a binary defect map.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_push/req_full): one defect flag per request in raster
//   order. A request is taken on a clock edge with req_push high and req_full
//   low. Back-to-back requests are taken one per cycle while req_full is low.
//   Result channel (rsp_empty/rsp_pop): queue-style; the oldest result sits on
//   rsp_row, rsp_column, rsp_flag_out and rsp_last while rsp_empty is low and
//   leaves on a clock edge with rsp_pop high. Each request causes zero to three
//   results; rsp_last marks the final one. One result leaves per cycle.
//   A taken request passes the front end's first stage into the queue; its
//   first result shows once its entry is the queue head. With req_full low,
//   requests flow one per cycle inside a line; a request at a line end or in
//   the last row has up to three results; the four-entry queue absorbs bursts.
//   Configuration (csr_valid/csr_ready): always ready; writes are for an idle
//   block. Writing line_length or line_count restarts the frame.
//   Reset clears counters, queue and registers (filter off, 128 x 800). When
//   the receiver stalls, the queue fills and req_full rises; nothing is lost.
// ----------------------------------------------------------------------------
module isolated_point_removal_3x3 import ipr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_flag_in,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [ROW_W-1:0]      rsp_row,
   output logic [COL_W-1:0]      rsp_column,
   output logic                  rsp_flag_out,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ipr_entry_type     push_entry;
   ipr_entry_type     head_entry;
   logic              q_push;
   logic              q_pop;
   logic              q_empty;
   logic [QCNT_W-1:0] q_count;

   assign csr_ready = 1'b1;

   // Accept and classify requests
   ipr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_flag_in (req_flag_in),
      .req_full    (req_full),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_count     (q_count),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   // Decouple front and back
   ipr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty),
      .count      (q_count)
   );

   // Emit results one at a time
   ipr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_row      (rsp_row),
      .rsp_column   (rsp_column),
      .rsp_flag_out (rsp_flag_out),
      .rsp_last     (rsp_last)
   );

endmodule
